>>> design/sdspi_pkg.sv
// Package for the SD card SPI host sequencer: phase codes, command codes,
// item structures and the command frame helper. No dependencies.
`default_nettype none
package sdspi_pkg;

	localparam int BLOCK_BYTES_DEF = 512;
	localparam int CNT_W = 10;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		FN_INIT  = 2'd0,
		FN_READ  = 2'd1,
		FN_WRITE = 2'd2,
		FN_XCHG  = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		PH_IDLE       = 4'd0,
		PH_DUMMY      = 4'd1,
		PH_LEAD       = 4'd2,
		PH_FRAME      = 4'd3,
		PH_RESP_WAIT  = 4'd4,
		PH_RESP_TAIL  = 4'd5,
		PH_TOKEN_WAIT = 4'd6,
		PH_DATA_IN    = 4'd7,
		PH_TRAIL      = 4'd8,
		PH_DATA_OUT   = 4'd9,
		PH_BUSY_HIGH  = 4'd10,
		PH_BUSY_LOW   = 4'd11
	} phase_t;

	localparam logic [5:0] CMD_GO_IDLE  = 6'd0;
	localparam logic [5:0] CMD_IF_COND  = 6'd8;
	localparam logic [5:0] CMD_BLOCKLEN = 6'd16;
	localparam logic [5:0] CMD_READ     = 6'd17;
	localparam logic [5:0] CMD_WRITE    = 6'd24;
	localparam logic [5:0] CMD_OP_COND  = 6'd41;
	localparam logic [5:0] CMD_APP      = 6'd55;

	localparam logic [7:0] BYTE_IDLE  = 8'hFF;
	localparam logic [7:0] TOKEN_DATA = 8'hFE;

	// item after classification, front to back
	typedef struct packed {
		logic        start;
		logic        start_init;
		logic        start_read;
		logic [31:0] addr;
		logic [7:0]  miso;
		logic [7:0]  wbyte;
	} item_t;

	// one result item
	typedef struct packed {
		logic       busy_res;
		logic       job_done;
		logic       status_valid;
		logic [7:0] status_byte;
		logic       read_valid;
		logic [7:0] read_byte;
		logic       took_write_byte;
		logic       mosi_valid;
		logic [7:0] mosi_byte;
	} result_t;

	// byte k of a command frame
	function automatic logic [7:0] frame_byte(input logic [5:0] cmd, input logic [2:0] k,
			input logic [31:0] haddr, input logic [31:0] blen);
		logic [31:0] arg;
		logic [7:0]  b;
		case (cmd)
			CMD_IF_COND:           arg = 32'h0000_01AA;
			CMD_OP_COND:           arg = 32'h4000_0000;
			CMD_BLOCKLEN:          arg = blen;
			CMD_READ, CMD_WRITE:   arg = haddr;
			default:               arg = 32'd0;
		endcase
		case (k)
			3'd0: b = {2'b01, cmd};
			3'd1: b = arg[31:24];
			3'd2: b = arg[23:16];
			3'd3: b = arg[15:8];
			3'd4: b = arg[7:0];
			default: begin
				case (cmd)
					CMD_GO_IDLE:  b = 8'h95;
					CMD_IF_COND:  b = 8'h87;
					CMD_BLOCKLEN: b = 8'hFF;
					default:      b = 8'h00;
				endcase
			end
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

>>> design/sdspi_front.sv
// Front part: accepts input transactions and classifies them into items.
// Depends on sdspi_pkg.
`default_nettype none
module sdspi_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        func,
	input  wire logic [31:0]       addr,
	input  wire logic [7:0]        miso,
	input  wire logic [7:0]        wbyte,
	output logic                   q_valid,
	input  wire logic              q_ready,
	output sdspi_pkg::item_t       q_item
);
	import sdspi_pkg::*;

	item_t it_q;
	logic  v_q;

	assign in_ready = !v_q || q_ready;
	assign q_valid  = v_q;
	assign q_item   = it_q;

	// register stage holding one classified item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			it_q.start      <= (func != FN_XCHG);
			it_q.start_init <= (func == FN_INIT);
			it_q.start_read <= (func == FN_READ);
			it_q.addr       <= addr;
			it_q.miso       <= miso;
			it_q.wbyte      <= wbyte;
		end
	end

`ifndef SYNTHESIS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_q && !q_ready |=> v_q && $stable(it_q)) else $error("front item lost");
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		v_q && it_q.start_init |-> it_q.start) else $error("bad classification");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_q |-> in_ready) else $error("front stalls while empty");
`endif

endmodule
`default_nettype wire

>>> design/sdspi_queue.sv
// Short FIFO between front and back parts. Depends on sdspi_pkg.
`default_nettype none
module sdspi_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_valid,
	output logic                   wr_ready,
	input  wire sdspi_pkg::item_t  wr_item,
	output logic                   rd_valid,
	input  wire logic              rd_ready,
	output sdspi_pkg::item_t       rd_item
);
	import sdspi_pkg::*;

	item_t      mem_q [QUEUE_DEPTH];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign wr_ready = (cnt_q != 2'(QUEUE_DEPTH));
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_item  = mem_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop  = rd_valid && rd_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_item;
	end

`ifndef SYNTHESIS
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(QUEUE_DEPTH)) else $error("queue overflow");
	a_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd0 || cnt_q == 2'(QUEUE_DEPTH) |-> wp_q == rp_q) else $error("pointer slip");
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> cnt_q == $past(cnt_q) - 2'd1) else $error("count slip");
`endif

endmodule
`default_nettype wire

>>> design/sdspi_back.sv
// Back part: the card sequencer, one step per item, with an output register.
// Depends on sdspi_pkg.
`default_nettype none
module sdspi_back #(
	parameter int BLOCK_BYTES = sdspi_pkg::BLOCK_BYTES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_valid,
	output logic                   q_ready,
	input  wire sdspi_pkg::item_t  q_item,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output sdspi_pkg::result_t     out_res
);
	import sdspi_pkg::*;

	localparam logic [CNT_W-1:0] BLK = CNT_W'(BLOCK_BYTES);

	phase_t           phase_q, phase_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [31:0]      addr_q, addr_d;
	logic [7:0]       resp_q, resp_d;
	logic [5:0]       cmd_q, cmd_d;
	logic             isrd_q, isrd_d;
	result_t          r, res_q;
	logic             ov_q, step;

	assign q_ready   = !ov_q || out_ready;
	assign step      = q_valid && q_ready;
	assign out_valid = ov_q;
	assign out_res   = res_q;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			addr_q  <= '0;
			resp_q  <= BYTE_IDLE;
			cmd_q   <= '0;
			isrd_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (q_ready) ov_q <= q_valid;
			if (step) begin
				phase_q <= phase_d;
				cnt_q   <= cnt_d;
				addr_q  <= addr_d;
				resp_q  <= resp_d;
				cmd_q   <= cmd_d;
				isrd_q  <= isrd_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) res_q <= r;
	end

	// next state and result
	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		addr_d  = addr_q;
		resp_d  = resp_q;
		cmd_d   = cmd_q;
		isrd_d  = isrd_q;
		r       = '0;
		if (q_item.start) begin
			r.mosi_byte = BYTE_IDLE;
			r.mosi_valid = 1'b1;
			if (q_item.start_init) begin
				phase_d = PH_DUMMY;
				cnt_d = CNT_W'(1);
			end else begin
				addr_d = q_item.addr;
				isrd_d = q_item.start_read;
				phase_d = PH_LEAD;
				cnt_d = '0;
			end
		end else begin
			case (phase_q)
				PH_DUMMY: begin
					r.mosi_valid = 1'b1;
					if (cnt_q < CNT_W'(12)) begin
						cnt_d = cnt_q + 1'b1;
						r.mosi_byte = BYTE_IDLE;
					end else begin
						cmd_d = CMD_GO_IDLE; phase_d = PH_FRAME; cnt_d = CNT_W'(1);
						r.mosi_byte = frame_byte(CMD_GO_IDLE, 3'd0, addr_q, 32'(BLOCK_BYTES));
					end
				end
				PH_LEAD: begin
					cmd_d = isrd_q ? CMD_READ : CMD_WRITE;
					phase_d = PH_FRAME; cnt_d = CNT_W'(1);
					r.mosi_valid = 1'b1;
					r.mosi_byte = {2'b01, cmd_d};
				end
				PH_FRAME: begin
					r.mosi_valid = 1'b1;
					if (cnt_q < CNT_W'(6)) begin
						r.mosi_byte = frame_byte(cmd_q, cnt_q[2:0], addr_q, 32'(BLOCK_BYTES));
						cnt_d = cnt_q + 1'b1;
					end else begin
						phase_d = PH_RESP_WAIT;
						r.mosi_byte = BYTE_IDLE;
					end
				end
				PH_RESP_WAIT: begin
					r.mosi_valid = 1'b1;
					r.mosi_byte = BYTE_IDLE;
					if (q_item.miso != BYTE_IDLE) begin
						resp_d = q_item.miso;
						if (cmd_q == CMD_READ || cmd_q == CMD_WRITE) begin
							if (q_item.miso != 8'h00) begin
								phase_d = PH_FRAME; cnt_d = CNT_W'(1);
								r.mosi_byte = {2'b01, cmd_q};
							end else if (cmd_q == CMD_READ) begin
								phase_d = PH_TOKEN_WAIT;
							end else begin
								phase_d = PH_DATA_OUT; cnt_d = '0;
								r.mosi_byte = TOKEN_DATA;
							end
						end else begin
							phase_d = PH_RESP_TAIL; cnt_d = '0;
						end
					end
				end
				PH_RESP_TAIL: begin
					cnt_d = cnt_q + 1'b1;
					if (cnt_d < CNT_W'(5)) begin
						r.mosi_valid = 1'b1;
						r.mosi_byte = BYTE_IDLE;
					end else begin
						case (cmd_q)
							CMD_GO_IDLE: begin
								r.status_valid = 1'b1; cmd_d = CMD_IF_COND;
							end
							CMD_IF_COND: begin
								r.status_valid = 1'b1; cmd_d = CMD_APP;
							end
							CMD_APP: cmd_d = CMD_OP_COND;
							CMD_OP_COND: begin
								if (resp_q == 8'h00) begin
									r.status_valid = 1'b1; cmd_d = CMD_BLOCKLEN;
								end else begin
									cmd_d = CMD_APP;
								end
							end
							default: begin
								r.status_valid = 1'b1; r.job_done = 1'b1;
								phase_d = PH_IDLE;
							end
						endcase
						if (r.status_valid) r.status_byte = resp_q;
						if (!r.job_done) begin
							phase_d = PH_FRAME; cnt_d = CNT_W'(1);
							r.mosi_valid = 1'b1;
							r.mosi_byte = {2'b01, cmd_d};
						end
					end
				end
				PH_TOKEN_WAIT: begin
					if (q_item.miso == TOKEN_DATA) begin
						resp_d = q_item.miso; phase_d = PH_DATA_IN; cnt_d = '0;
					end
					r.mosi_valid = 1'b1; r.mosi_byte = BYTE_IDLE;
				end
				PH_DATA_IN: begin
					r.read_byte = q_item.miso; r.read_valid = 1'b1;
					cnt_d = cnt_q + 1'b1;
					if (cnt_d >= BLK) phase_d = PH_TRAIL;
					r.mosi_valid = 1'b1; r.mosi_byte = BYTE_IDLE;
				end
				PH_TRAIL: begin
					r.status_byte = resp_q; r.status_valid = 1'b1;
					r.job_done = 1'b1; phase_d = PH_IDLE;
				end
				PH_DATA_OUT: begin
					r.mosi_valid = 1'b1;
					if (cnt_q < BLK) begin
						r.mosi_byte = q_item.wbyte; r.took_write_byte = 1'b1;
						cnt_d = cnt_q + 1'b1;
					end else begin
						phase_d = PH_BUSY_HIGH; r.mosi_byte = BYTE_IDLE;
					end
				end
				PH_BUSY_HIGH: begin
					if (q_item.miso != BYTE_IDLE) phase_d = PH_BUSY_LOW;
					r.mosi_valid = 1'b1; r.mosi_byte = BYTE_IDLE;
				end
				PH_BUSY_LOW: begin
					if (q_item.miso == 8'h00) begin
						r.mosi_valid = 1'b1; r.mosi_byte = BYTE_IDLE;
					end else begin
						resp_d = q_item.miso;
						r.status_byte = q_item.miso; r.status_valid = 1'b1;
						r.job_done = 1'b1; phase_d = PH_IDLE;
					end
				end
				default: phase_d = PH_IDLE;
			endcase
		end
		r.busy_res = (phase_d != PH_IDLE);
	end

`ifndef SYNTHESIS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !out_ready |=> ov_q && $stable(res_q)) else $error("result lost");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		step && r.job_done |-> !r.busy_res && r.status_valid) else $error("done while busy");
	a_took: assert property (@(posedge clk) disable iff (!arst_n)
		step && r.took_write_byte |-> r.mosi_valid) else $error("write byte not sent");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA_IN |-> cnt_q < BLK) else $error("data count overrun");
`endif

endmodule
`default_nettype wire

>>> design/sd_card_spi_host_sequencer.sv
// SD card SPI-mode host sequencer, top level. Depends on sdspi_pkg, sdspi_front,
// sdspi_queue and sdspi_back.
// m_axis_tvalid rises once the input transaction has passed the front register,
// the queue entry and the output register. Throughput: one item per cycle while
// m_axis_tready is high, set by the single step of the back part's phase logic.
// Reset (arst_n low) puts the sequencer idle, clears the queue and drops
// m_axis_tvalid.
`default_nettype none
module sd_card_spi_host_sequencer #(
	parameter int BLOCK_BYTES = sdspi_pkg::BLOCK_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [31:0] block_address, [39:32] miso_byte, [47:40] write_byte
	input  wire logic [47:0] s_axis_tdata,
	// [1:0] func
	input  wire logic [1:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [7:0] mosi_byte, [15:8] read_byte, [23:16] status_byte
	output logic [23:0]      m_axis_tdata,
	// [0] mosi_valid, [1] took_write_byte, [2] read_valid, [3] status_valid,
	// [4] job_done, [5] busy_res
	output logic [5:0]       m_axis_tuser
);
	import sdspi_pkg::*;

	item_t   f_item, b_item;
	logic    f_valid, f_ready, b_valid, b_ready;
	result_t res;

	sdspi_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.func(s_axis_tuser), .addr(s_axis_tdata[31:0]),
		.miso(s_axis_tdata[39:32]), .wbyte(s_axis_tdata[47:40]),
		.q_valid(f_valid), .q_ready(f_ready), .q_item(f_item)
	);

	sdspi_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_item(b_item)
	);

	sdspi_back #(.BLOCK_BYTES(BLOCK_BYTES)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(b_valid), .q_ready(b_ready), .q_item(b_item),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
	);

	// pack result
	assign m_axis_tdata = {res.status_byte, res.read_byte, res.mosi_byte};
	assign m_axis_tuser = {res.busy_res, res.job_done, res.status_valid,
		res.read_valid, res.took_write_byte, res.mosi_valid};

endmodule
`default_nettype wire

>>> bench/testbench.sv
// Testbench for the SD card SPI host sequencer: drives init, read and write jobs
// through the input stream and checks every result against a behavioural predictor.
// Depends on sdspi_pkg and sd_card_spi_host_sequencer.
`timescale 1ns / 100ps
module testbench;
	import sdspi_pkg::*;

	localparam int NBYTES = 512;
	localparam longint CYCLE_LIMIT = 3000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic [5:0]  m_axis_tuser;

	sd_card_spi_host_sequencer #(.BLOCK_BYTES(NBYTES)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor state
	phase_t      pr_phase = PH_IDLE;
	int unsigned pr_count = 0;
	logic [31:0] pr_addr = '0;
	logic [7:0]  pr_resp = 8'hFF;
	logic [5:0]  pr_cmd = '0;
	logic        pr_is_read = 1'b0;
	result_t     pr_res;

	result_t     expected_results[$];
	int          errors = 0;
	longint      cycles = 0;
	bit          quiet = 1'b0;	// no idling in the final part
	int          hold_off = 0;	// long receiver stall

	// count of input transactions sent
	int          items_sent = 0;

	function automatic logic [7:0] cmd_frame_byte(logic [5:0] cmd, int k);
		logic [31:0] arg;
		case (cmd)
			CMD_IF_COND: arg = 32'h0000_01AA;
			CMD_OP_COND: arg = 32'h4000_0000;
			CMD_BLOCKLEN: arg = NBYTES;
			CMD_READ, CMD_WRITE: arg = pr_addr;
			default: arg = '0;
		endcase
		case (k)
			0: return {2'b01, cmd};
			1: return arg[31:24];
			2: return arg[23:16];
			3: return arg[15:8];
			4: return arg[7:0];
			default: begin
				if (cmd == CMD_GO_IDLE) return 8'h95;
				if (cmd == CMD_IF_COND) return 8'h87;
				if (cmd == CMD_BLOCKLEN) return 8'hFF;
				return 8'h00;
			end
		endcase
	endfunction

	task automatic put_byte(logic [7:0] b);
		pr_res.mosi_byte = b;
		pr_res.mosi_valid = 1'b1;
	endtask

	task automatic begin_frame(logic [5:0] cmd);
		pr_cmd = cmd;
		pr_phase = PH_FRAME;
		pr_count = 1;
		put_byte(cmd_frame_byte(cmd, 0));
	endtask

	task automatic post_status(logic [7:0] b);
		pr_res.status_byte = b;
		pr_res.status_valid = 1'b1;
	endtask

	task automatic response_done();
		case (pr_cmd)
			CMD_GO_IDLE: begin post_status(pr_resp); begin_frame(CMD_IF_COND); end
			CMD_IF_COND: begin post_status(pr_resp); begin_frame(CMD_APP); end
			CMD_APP: begin_frame(CMD_OP_COND);
			CMD_OP_COND: begin
				if (pr_resp == 8'h00) begin
					post_status(pr_resp);
					begin_frame(CMD_BLOCKLEN);
				end else
					begin_frame(CMD_APP);
			end
			default: begin
				post_status(pr_resp);
				pr_res.job_done = 1'b1;
				pr_phase = PH_IDLE;
			end
		endcase
	endtask

	task automatic predict_exchange(logic [7:0] miso, logic [7:0] wb);
		case (pr_phase)
			PH_DUMMY: begin
				if (pr_count < 12) begin pr_count++; put_byte(BYTE_IDLE); end
				else begin_frame(CMD_GO_IDLE);
			end
			PH_LEAD: begin_frame(pr_is_read ? CMD_READ : CMD_WRITE);
			PH_FRAME: begin
				if (pr_count < 6) begin
					put_byte(cmd_frame_byte(pr_cmd, pr_count));
					pr_count++;
				end else begin
					pr_phase = PH_RESP_WAIT;
					put_byte(BYTE_IDLE);
				end
			end
			PH_RESP_WAIT: begin
				if (miso == 8'hFF) put_byte(BYTE_IDLE);
				else begin
					pr_resp = miso;
					if (pr_cmd == CMD_READ || pr_cmd == CMD_WRITE) begin
						if (miso != 8'h00) begin_frame(pr_cmd);
						else if (pr_cmd == CMD_READ) begin
							pr_phase = PH_TOKEN_WAIT;
							put_byte(BYTE_IDLE);
						end else begin
							pr_phase = PH_DATA_OUT;
							pr_count = 0;
							put_byte(TOKEN_DATA);
						end
					end else begin
						pr_phase = PH_RESP_TAIL;
						pr_count = 0;
						put_byte(BYTE_IDLE);
					end
				end
			end
			PH_RESP_TAIL: begin
				pr_count++;
				if (pr_count < 5) put_byte(BYTE_IDLE);
				else response_done();
			end
			PH_TOKEN_WAIT: begin
				if (miso == TOKEN_DATA) begin
					pr_resp = miso;
					pr_phase = PH_DATA_IN;
					pr_count = 0;
				end
				put_byte(BYTE_IDLE);
			end
			PH_DATA_IN: begin
				pr_res.read_byte = miso;
				pr_res.read_valid = 1'b1;
				pr_count++;
				if (pr_count >= NBYTES) pr_phase = PH_TRAIL;
				put_byte(BYTE_IDLE);
			end
			PH_TRAIL: begin
				post_status(pr_resp);
				pr_res.job_done = 1'b1;
				pr_phase = PH_IDLE;
			end
			PH_DATA_OUT: begin
				if (pr_count < NBYTES) begin
					put_byte(wb);
					pr_res.took_write_byte = 1'b1;
					pr_count++;
				end else begin
					pr_phase = PH_BUSY_HIGH;
					put_byte(BYTE_IDLE);
				end
			end
			PH_BUSY_HIGH: begin
				if (miso != 8'hFF) pr_phase = PH_BUSY_LOW;
				put_byte(BYTE_IDLE);
			end
			PH_BUSY_LOW: begin
				if (miso == 8'h00) put_byte(BYTE_IDLE);
				else begin
					pr_resp = miso;
					post_status(miso);
					pr_res.job_done = 1'b1;
					pr_phase = PH_IDLE;
				end
			end
			default: pr_phase = PH_IDLE;
		endcase
	endtask

	task automatic predict_step(func_t fn, logic [31:0] addr, logic [7:0] miso, logic [7:0] wb);
		pr_res = '0;
		if (fn == FN_INIT) begin
			pr_phase = PH_DUMMY;
			pr_count = 1;
			put_byte(BYTE_IDLE);
		end else if (fn == FN_READ || fn == FN_WRITE) begin
			pr_addr = addr;
			pr_is_read = (fn == FN_READ);
			pr_phase = PH_LEAD;
			pr_count = 0;
			put_byte(BYTE_IDLE);
		end else if (pr_phase != PH_IDLE)
			predict_exchange(miso, wb);
		pr_res.busy_res = (pr_phase != PH_IDLE);
		expected_results.push_back(pr_res);
	endtask

	// send one transaction, at random with an idle burst before it unless quiet;
	// tvalid stays high after acceptance until the next idle stretch
	task automatic send_item(func_t fn, logic [31:0] addr, logic [7:0] miso, logic [7:0] wb);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= fn;
		s_axis_tdata <= {wb, miso, addr};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_step(fn, addr, miso, wb);
		items_sent++;
	endtask

	task automatic xchg(logic [7:0] miso);
		send_item(FN_XCHG, $urandom, miso, 8'($urandom_range(0, 255)));
	endtask

	// card reply: the first non-FF byte after up to two FF bytes
	task automatic card_reply(logic [7:0] head);
		repeat ($urandom_range(0, 2)) xchg(8'hFF);
		xchg(head);
	endtask

	// stop offering and wait until every expected result has arrived
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	// walks the sequencer through whatever phase it is in with sensible card bytes
	task automatic run_to_idle(int max_steps, bit rand_heads);
		int n;
		logic [7:0] b;
		for (n = 0; n < max_steps && pr_phase != PH_IDLE; n++) begin
			case (pr_phase)
				PH_RESP_WAIT: begin
					if ($urandom_range(0, 2) == 0) b = 8'hFF;
					else if (rand_heads && $urandom_range(0, 3) == 0)
						b = 8'($urandom_range(0, 254));
					else if (pr_cmd == CMD_OP_COND && $urandom_range(0, 1) == 0) b = 8'h01;
					else b = (pr_cmd == CMD_GO_IDLE) ? 8'h01 : 8'h00;
				end
				PH_TOKEN_WAIT:
					b = ($urandom_range(0, 2) == 0) ? TOKEN_DATA : 8'($urandom_range(0, 255));
				PH_BUSY_HIGH:
					b = ($urandom_range(0, 1) == 0) ? 8'hFF : 8'($urandom_range(0, 255));
				PH_BUSY_LOW:
					b = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
				default: b = 8'($urandom_range(0, 255));
			endcase
			xchg(b);
		end
	endtask

	task automatic test_reset_idle();
		// exchanges while idle are ignored
		xchg(8'h00);
		xchg(8'hFF);
		xchg(8'hA5);
	endtask

	task automatic test_init();
		send_item(FN_INIT, '0, 8'h00, 8'h00);
		run_to_idle(400, 1'b0);
	endtask

	task automatic test_read();
		send_item(FN_READ, 32'hFFFF_FFFF, 8'h00, 8'hFF);
		repeat (7) xchg(8'($urandom));
		card_reply(8'h05);	// non-zero head forces a retry
		repeat (6) xchg(8'($urandom));
		card_reply(8'h00);
		xchg(8'h12);
		xchg(TOKEN_DATA);
		repeat (NBYTES) xchg(8'($urandom));
		xchg(8'hFF);
	endtask

	task automatic test_write();
		send_item(FN_WRITE, 32'h0000_0000, 8'hFF, 8'h00);
		repeat (7) xchg(8'($urandom));
		card_reply(8'h00);
		repeat (NBYTES + 1) send_item(FN_XCHG, $urandom, 8'($urandom), 8'($urandom));
		xchg(8'hFF);
		xchg(8'h00);
		xchg(8'h00);
		xchg(8'hE5);
	endtask

	task automatic test_abandon();
		// start while busy abandons the running job
		send_item(FN_READ, 32'h1234_5678, 8'h00, 8'h00);
		repeat (3) xchg(8'h00);
		send_item(FN_INIT, 32'hDEAD_BEEF, 8'hFF, 8'hFF);
		repeat (5) xchg(8'hFF);
		send_item(FN_WRITE, 32'h8000_0001, 8'h00, 8'h00);
		run_to_idle(80, 1'b1);
	endtask

	task automatic test_random(int target);
		int pick;
		while (items_sent < target) begin
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				send_item(func_t'($urandom_range(0, 2)), $urandom, 8'($urandom),
					8'($urandom));
				run_to_idle($urandom_range(1, 60), 1'b1);
			end else
				send_item(func_t'($urandom_range(0, 3)), $urandom, 8'($urandom),
					8'($urandom));
		end
	endtask

	task automatic test_backpressure();
		// receiver holds off while the sender keeps offering
		hold_off = 200;
		send_item(FN_INIT, '0, 8'h00, 8'h00);
		run_to_idle(60, 1'b0);
		// sender pause until everything has arrived
		drain();
		run_to_idle(3000, 1'b0);
	endtask

	// random stall bursts for the receiver
	int stall_left = 0;
	always @(posedge clk) begin
		if (stall_left != 0) stall_left <= stall_left - 1;
		else if (!quiet && $urandom_range(0, 30) == 0) stall_left <= $urandom_range(1, 11);
	end

	// receiver: stall bursts, long hold-off on request
	always @(posedge clk) begin
		if (hold_off != 0) begin
			hold_off <= hold_off - 1;
			m_axis_tready <= 1'b0;
		end else if (!quiet && stall_left != 0)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= 1'b1;
	end

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		result_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got.mosi_byte = m_axis_tdata[7:0];
			got.read_byte = m_axis_tdata[15:8];
			got.status_byte = m_axis_tdata[23:16];
			got.mosi_valid = m_axis_tuser[0];
			got.took_write_byte = m_axis_tuser[1];
			got.read_valid = m_axis_tuser[2];
			got.status_valid = m_axis_tuser[3];
			got.job_done = m_axis_tuser[4];
			got.busy_res = m_axis_tuser[5];
			if (expected_results.size() == 0)
				report_mismatch("unexpected transaction", got.mosi_byte, 0);
			else begin
				want = expected_results.pop_front();
				if (got.mosi_byte != want.mosi_byte)
					report_mismatch("mosi_byte", got.mosi_byte, want.mosi_byte);
				if (got.mosi_valid != want.mosi_valid)
					report_mismatch("mosi_valid", got.mosi_valid, want.mosi_valid);
				if (got.took_write_byte != want.took_write_byte)
					report_mismatch("took_write_byte", got.took_write_byte,
						want.took_write_byte);
				if (got.read_byte != want.read_byte)
					report_mismatch("read_byte", got.read_byte, want.read_byte);
				if (got.read_valid != want.read_valid)
					report_mismatch("read_valid", got.read_valid, want.read_valid);
				if (got.status_byte != want.status_byte)
					report_mismatch("status_byte", got.status_byte, want.status_byte);
				if (got.status_valid != want.status_valid)
					report_mismatch("status_valid", got.status_valid, want.status_valid);
				if (got.job_done != want.job_done)
					report_mismatch("job_done", got.job_done, want.job_done);
				if (got.busy_res != want.busy_res)
					report_mismatch("busy_res", got.busy_res, want.busy_res);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_idle();
		test_init();
		test_read();
		test_write();
		test_abandon();
		test_backpressure();
		test_random(items_sent + 120);
		quiet = 1'b1;
		test_random(items_sent + 80);
		drain();
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> sim.f
design/sdspi_pkg.sv
design/sdspi_front.sv
design/sdspi_queue.sv
design/sdspi_back.sv
design/sd_card_spi_host_sequencer.sv
bench/testbench.sv
